// ----- hw/rtl/dslp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dslp_pkg
// Shared types and constants for the DNS search list label parser.
// ----------------------------------------------------------------------------
package dslp_pkg;

	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_DROP = 2'd2;

	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_DOT  = 8'h2E;
	localparam logic [7:0] CH_DASH = 8'h2D;

	localparam logic [6:0] LABEL_LIMIT_RST  = 7'd64;
	localparam logic [8:0] DOMAIN_LIMIT_RST = 9'd256;

	localparam logic REG_LABEL_LIMIT  = 1'b0;
	localparam logic REG_DOMAIN_LIMIT = 1'b1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = 1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       option_end;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic [1:0] kind;
		logic       last;
	} out_beat_t;

	// one classified input byte: a first result and an optional trailing discard
	typedef struct packed {
		logic [7:0] ch;
		logic [1:0] kind;
		logic       two;
	} entry_t;

endpackage

// ----- hw/rtl/dns_search_list_label_parser_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_search_list_label_parser_unit
// Decodes length-prefixed DNS search list labels into dotted text with
// letter-digit-hyphen checks.
// Each accepted byte's queue entry is registered before its beats are presented.
// Throughput: one byte per cycle while in_stall is low; a byte with two results
// takes two output beats and can stall the input when bytes follow back to back.
// Reset: asynchronous; parser returns to domain start, queue empties,
// label_limit to 64 and domain_limit to 256.
// ----------------------------------------------------------------------------
module dns_search_list_label_parser_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  dslp_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output dslp_pkg::out_beat_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic [6:0] label_limit_q;
	logic [8:0] domain_limit_q;
	logic       reg_sel;
	logic       full, push, pop, head_valid;

	dslp_pkg::entry_t wr_entry, head;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];

	always_comb begin
		case (reg_sel)
			dslp_pkg::REG_LABEL_LIMIT:  prdata = {25'd0, label_limit_q};
			dslp_pkg::REG_DOMAIN_LIMIT: prdata = {23'd0, domain_limit_q};
			default:                    prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			label_limit_q  <= dslp_pkg::LABEL_LIMIT_RST;
			domain_limit_q <= dslp_pkg::DOMAIN_LIMIT_RST;
		end else if (psel && penable && pwrite && pready) begin
			if (reg_sel == dslp_pkg::REG_LABEL_LIMIT) begin
				label_limit_q <= pwdata[6:0];
			end else begin
				domain_limit_q <= pwdata[8:0];
			end
		end
	end

	assign in_stall = full;

	dslp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_data      (in_data),
		.full         (full),
		.label_limit  (label_limit_q),
		.domain_limit (domain_limit_q),
		.push         (push),
		.entry        (wr_entry)
	);

	dslp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_entry   (wr_entry),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head       (head)
	);

	dslp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

// ----- hw/rtl/dslp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dslp_front
// Label parser state machine: classifies each body byte into queue entries.
// ----------------------------------------------------------------------------
module dslp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  dslp_pkg::in_beat_t in_data,
	input  logic              full,
	input  logic [6:0]        label_limit,
	input  logic [8:0]        domain_limit,
	output logic              push,
	output dslp_pkg::entry_t  entry
);

	typedef enum logic [2:0] {
		MODE_START = 3'd0,
		MODE_LABEL = 3'd1,
		MODE_AFTER = 3'd2,
		MODE_SKIP  = 3'd3,
		MODE_PAD   = 3'd4
	} mode_t;

	mode_t      mode_q, mode_n, mode_d;
	logic [6:0] label_len_q, label_len_n;
	logic [6:0] label_pos_q, label_pos_n;
	logic [8:0] dom_len_q, dom_len_n;

	logic [7:0]  b;
	logic        accept;
	logic        dot_cost;
	logic [10:0] fit_sum;
	logic        len_ok;
	logic        is_letter, is_digit, ch_ok;
	logic [7:0]  pos_inc;
	logic [6:0]  pos_next;
	logic        r0_valid;
	logic [7:0]  r0_ch;
	logic [1:0]  r0_kind;
	logic        drop2;

	assign b      = in_data.data_byte;
	assign accept = in_valid && !full;

	assign dot_cost = (mode_q == MODE_AFTER);
	assign fit_sum  = {2'b00, dom_len_q} + {10'd0, dot_cost} + {3'd0, b} + 11'd2;
	assign len_ok   = (b <= {1'b0, label_limit}) && (fit_sum < {2'b00, domain_limit});

	assign is_letter = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
	assign is_digit  = (b >= 8'h30 && b <= 8'h39);
	assign pos_inc   = {1'b0, label_pos_q} + 8'd1;
	assign pos_next  = pos_inc[6:0];

	always_comb begin
		if (label_pos_q == 7'd0) begin
			ch_ok = is_letter;
		end else if (pos_inc == {1'b0, label_len_q}) begin
			ch_ok = is_letter || is_digit;
		end else begin
			ch_ok = is_letter || is_digit || (b == dslp_pkg::CH_DASH);
		end
	end

	always_comb begin
		mode_n      = mode_q;
		label_len_n = label_len_q;
		label_pos_n = label_pos_q;
		dom_len_n   = dom_len_q;
		r0_valid    = 1'b0;
		r0_ch       = dslp_pkg::CH_NUL;
		r0_kind     = dslp_pkg::KIND_CHAR;
		case (mode_q)
			MODE_START, MODE_AFTER: begin
				if (b == dslp_pkg::CH_NUL) begin
					if (mode_q == MODE_AFTER) begin
						r0_valid    = 1'b1;
						r0_kind     = dslp_pkg::KIND_DONE;
						label_len_n = 7'd0;
						label_pos_n = 7'd0;
						dom_len_n   = 9'd0;
						mode_n      = MODE_START;
					end else begin
						mode_n = MODE_PAD;
					end
				end else if (len_ok) begin
					if (dot_cost) begin
						r0_valid  = 1'b1;
						r0_ch     = dslp_pkg::CH_DOT;
						dom_len_n = dom_len_q + 9'd1;
					end
					label_len_n = b[6:0];
					label_pos_n = 7'd0;
					mode_n      = MODE_LABEL;
				end else begin
					r0_valid    = 1'b1;
					r0_kind     = dslp_pkg::KIND_DROP;
					label_len_n = 7'd0;
					label_pos_n = 7'd0;
					dom_len_n   = 9'd0;
					mode_n      = MODE_SKIP;
				end
			end
			MODE_LABEL: begin
				r0_valid = 1'b1;
				if (ch_ok) begin
					r0_ch       = b;
					dom_len_n   = dom_len_q + 9'd1;
					label_pos_n = pos_next;
					if (pos_next >= label_len_q) begin
						mode_n = MODE_AFTER;
					end
				end else begin
					r0_kind     = dslp_pkg::KIND_DROP;
					label_len_n = 7'd0;
					label_pos_n = 7'd0;
					dom_len_n   = 9'd0;
					mode_n      = (b == dslp_pkg::CH_NUL) ? MODE_START : MODE_SKIP;
				end
			end
			MODE_SKIP: begin
				if (b == dslp_pkg::CH_NUL) begin
					mode_n = MODE_START;
				end
			end
			default: begin
				mode_n = MODE_PAD;
			end
		endcase
	end

	always_comb begin
		drop2  = 1'b0;
		mode_d = mode_n;
		if (in_data.option_end) begin
			drop2  = (mode_n == MODE_LABEL) || (mode_n == MODE_AFTER);
			mode_d = MODE_START;
		end
	end

	always_comb begin
		if (r0_valid) begin
			entry.ch   = r0_ch;
			entry.kind = r0_kind;
			entry.two  = drop2;
		end else begin
			entry.ch   = dslp_pkg::CH_NUL;
			entry.kind = dslp_pkg::KIND_DROP;
			entry.two  = 1'b0;
		end
	end

	assign push = accept && (r0_valid || drop2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_START;
			label_len_q <= 7'd0;
			label_pos_q <= 7'd0;
			dom_len_q   <= 9'd0;
		end else if (accept) begin
			mode_q <= mode_d;
			if (in_data.option_end) begin
				label_len_q <= 7'd0;
				label_pos_q <= 7'd0;
				dom_len_q   <= 9'd0;
			end else begin
				label_len_q <= label_len_n;
				label_pos_q <= label_pos_n;
				dom_len_q   <= dom_len_n;
			end
		end
	end

endmodule

// ----- hw/rtl/dslp_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dslp_queue
// Short entry queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module dslp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dslp_pkg::entry_t wr_entry,
	input  logic             pop,
	output logic             full,
	output logic             head_valid,
	output dslp_pkg::entry_t head
);

	dslp_pkg::entry_t mem_q [dslp_pkg::QUEUE_DEPTH];

	logic [dslp_pkg::QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [dslp_pkg::QUEUE_AW:0]   count_q;

	assign full       = (count_q == (dslp_pkg::QUEUE_AW+1)'(dslp_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (dslp_pkg::QUEUE_AW+1)'(dslp_pkg::QUEUE_DEPTH))
		else $error("queue count out of range");
`endif

endmodule

// ----- hw/rtl/dslp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dslp_back
// Result sequencer: expands each queue entry into one or two output beats.
// ----------------------------------------------------------------------------
module dslp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  dslp_pkg::entry_t    head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output dslp_pkg::out_beat_t out_data
);

	logic phase_q;
	logic take;

	assign out_valid = head_valid;
	assign take      = out_valid && !out_stall;
	assign pop       = take && (phase_q || !head.two);

	always_comb begin
		if (phase_q) begin
			out_data.out_char = dslp_pkg::CH_NUL;
			out_data.kind     = dslp_pkg::KIND_DROP;
			out_data.last     = 1'b1;
		end else begin
			out_data.out_char = head.ch;
			out_data.kind     = head.kind;
			out_data.last     = !head.two;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
		end else if (take) begin
			phase_q <= !phase_q && head.two;
		end
	end

`ifndef NO_ASSERTIONS
	a_phase_head: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (head_valid && head.two))
		else $error("second beat without a two-result entry");
`endif

endmodule

// ----- tb/tb_dns_search_list_label_parser_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dns_search_list_label_parser_unit
// Self-checking bench for the search list label parser. Option bodies are
// mostly well-formed label sequences with random content and occasional flaws
// (bad first, last or inner characters, oversize lengths, truncation, missing
// terminators, padding), mixed with random byte noise. A decoder kept in the
// bench predicts every result beat, and the monitor compares each accepted
// beat against the oldest prediction. Register settings are changed between
// phases through the APB port and read back.
// ----------------------------------------------------------------------------
module tb_dns_search_list_label_parser_unit;

	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_PRINTS  = 100;
	localparam int N_SETTINGS  = 7;

	typedef enum logic [2:0] {PM_START, PM_LABEL, PM_AFTER, PM_SKIP, PM_PAD} parse_mode_t;
	typedef enum int {FL_NONE, FL_FIRST, FL_LAST, FL_INNER, FL_LENGTH, FL_CUT} flaw_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	dslp_pkg::in_beat_t  in_data;
	logic                out_valid;
	logic                out_stall;
	dslp_pkg::out_beat_t out_data;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [2:0]          paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	dslp_pkg::in_beat_t  option_bytes_q[$];
	dslp_pkg::out_beat_t decoded_q[$];
	logic        in_fire;
	logic        out_hold;
	int          send_idle_pct;
	int          stall_pct;
	int          cycles;
	int          mismatches;
	int          items_queued;
	int          beats_checked;
	int          domains_done;
	int          domains_dropped;
	int          settings_run;

	// decoder state and register copies
	parse_mode_t pmode;
	int          lbl_len;
	int          lbl_pos;
	int          dom_len;
	logic [6:0]  cfg_label_limit;
	logic [8:0]  cfg_domain_limit;

	int label_set[N_SETTINGS]  = '{64, 1, 20, 127, 0, 64, 7};
	int domain_set[N_SETTINGS] = '{256, 16, 40, 511, 3, 256, 100};

	dns_search_list_label_parser_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(string what);
		if (mismatches < MAX_PRINTS) begin
			$display("[%0t] mismatch: %s", $time, what);
		end
		mismatches++;
	endtask

	function automatic bit is_letter(logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic void push_result(logic [7:0] ch, logic [1:0] kind);
		dslp_pkg::out_beat_t r;
		r.out_char = ch;
		r.kind     = kind;
		r.last     = 1'b0;
		decoded_q.push_back(r);
		if (kind == dslp_pkg::KIND_DONE) begin
			domains_done++;
		end else if (kind == dslp_pkg::KIND_DROP) begin
			domains_dropped++;
		end
	endfunction

	function automatic void clear_domain();
		lbl_len = 0;
		lbl_pos = 0;
		dom_len = 0;
	endfunction

	function automatic void take_length(logic [7:0] c, bit dot);
		if (c <= cfg_label_limit &&
				dom_len + int'(dot) + int'(c) + 2 < int'(cfg_domain_limit)) begin
			if (dot) begin
				push_result(dslp_pkg::CH_DOT, dslp_pkg::KIND_CHAR);
				dom_len++;
			end
			lbl_len = int'(c);
			lbl_pos = 0;
			pmode   = PM_LABEL;
		end else begin
			push_result(dslp_pkg::CH_NUL, dslp_pkg::KIND_DROP);
			clear_domain();
			pmode = PM_SKIP;
		end
	endfunction

	function automatic void decode_byte(dslp_pkg::in_beat_t beat);
		logic [7:0]          c;
		int                  n_before;
		bit                  lt;
		bit                  dg;
		bit                  ok;
		dslp_pkg::out_beat_t tail;
		c        = beat.data_byte;
		n_before = decoded_q.size();
		case (pmode)
			PM_START: begin
				if (c == dslp_pkg::CH_NUL) pmode = PM_PAD;
				else take_length(c, 1'b0);
			end
			PM_LABEL: begin
				lt = is_letter(c);
				dg = c >= "0" && c <= "9";
				if (lbl_pos == 0) ok = lt;
				else if (lbl_pos + 1 == lbl_len) ok = lt || dg;
				else ok = lt || dg || c == dslp_pkg::CH_DASH;
				if (ok) begin
					push_result(c, dslp_pkg::KIND_CHAR);
					dom_len = (dom_len + 1) & 'h1FF;
					lbl_pos = (lbl_pos + 1) & 'h7F;
					if (lbl_pos >= lbl_len) pmode = PM_AFTER;
				end else begin
					push_result(dslp_pkg::CH_NUL, dslp_pkg::KIND_DROP);
					clear_domain();
					pmode = (c == dslp_pkg::CH_NUL) ? PM_START : PM_SKIP;
				end
			end
			PM_AFTER: begin
				if (c == dslp_pkg::CH_NUL) begin
					push_result(dslp_pkg::CH_NUL, dslp_pkg::KIND_DONE);
					clear_domain();
					pmode = PM_START;
				end else begin
					take_length(c, 1'b1);
				end
			end
			PM_SKIP: begin
				if (c == dslp_pkg::CH_NUL) pmode = PM_START;
			end
			default: pmode = PM_PAD;
		endcase
		if (beat.option_end) begin
			if (pmode == PM_LABEL || pmode == PM_AFTER) begin
				push_result(dslp_pkg::CH_NUL, dslp_pkg::KIND_DROP);
			end
			clear_domain();
			pmode = PM_START;
		end
		if (decoded_q.size() > n_before) begin
			tail      = decoded_q.pop_back();
			tail.last = 1'b1;
			decoded_q.push_back(tail);
		end
	endfunction

	function automatic void offer(logic [7:0] b, bit e);
		dslp_pkg::in_beat_t x;
		x.data_byte  = b;
		x.option_end = e;
		option_bytes_q.push_back(x);
		items_queued++;
	endfunction

	function automatic logic [7:0] rand_letter();
		logic [7:0] base;
		base = $urandom_range(1) ? "a" : "A";
		return base + 8'($urandom_range(25));
	endfunction

	function automatic logic [7:0] label_char(int pos, int len);
		int pick;
		if (pos == 0) return rand_letter();
		pick = $urandom_range(pos == len - 1 ? 61 : 62);
		if (pick < 52) return rand_letter();
		if (pick < 62) return 8'("0" + pick - 52);
		return dslp_pkg::CH_DASH;
	endfunction

	function automatic void queue_option();
		logic [7:0] body[$];
		logic [7:0] lab[$];
		int         n_dom;
		int         n_lab;
		int         cap;
		int         len;
		int         keep;
		flaw_t      flaw;
		bit         cut;
		cut   = 1'b0;
		n_dom = $urandom_range(1, 3);
		for (int d = 0; d < n_dom && !cut; d++) begin
			n_lab = $urandom_range(1, 3);
			for (int l = 0; l < n_lab && !cut; l++) begin
				cap = cfg_label_limit < 10 ? int'(cfg_label_limit) : 10;
				if ($urandom_range(7) == 0) cap = int'(cfg_label_limit);
				len  = cap == 0 ? 1 : $urandom_range(1, cap);
				flaw = $urandom_range(9) == 0 ?
					flaw_t'($urandom_range(FL_CUT, FL_FIRST)) : FL_NONE;
				keep = flaw == FL_CUT ? $urandom_range(len - 1) : len;
				lab.delete();
				for (int i = 0; i < keep; i++) lab.push_back(label_char(i, len));
				case (flaw)
					FL_FIRST: lab[0] = $urandom_range(1) ? 8'("0" + $urandom_range(9)) :
						dslp_pkg::CH_DASH;
					FL_LAST: begin
						if (len > 1) lab[len - 1] = dslp_pkg::CH_DASH;
					end
					FL_INNER: lab[$urandom_range(len - 1)] = 8'($urandom_range(255));
					FL_CUT: cut = 1'b1;
					default: ;
				endcase
				if (flaw == FL_LENGTH) begin
					body.push_back($urandom_range(1) ? 8'(cfg_label_limit + 1) :
						8'($urandom_range(255, 128)));
				end else begin
					body.push_back(8'(len));
				end
				foreach (lab[i]) body.push_back(lab[i]);
			end
			if (!cut && (d < n_dom - 1 || $urandom_range(7) != 0)) begin
				body.push_back(dslp_pkg::CH_NUL);
			end
		end
		if (!cut && $urandom_range(4) == 0) begin
			body.push_back(dslp_pkg::CH_NUL);
			repeat ($urandom_range(3)) body.push_back(8'($urandom_range(255)));
		end
		foreach (body[i]) offer(body[i], i == body.size() - 1);
	endfunction

	function automatic void queue_noise();
		int n;
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++) begin
			offer(8'($urandom_range(255)), i == n - 1 || $urandom_range(15) == 0);
		end
	endfunction

	task automatic set_register(logic idx, logic [31:0] value);
		logic [31:0] mask;
		mask = idx == dslp_pkg::REG_LABEL_LIMIT ? 32'h7F : 32'h1FF;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== (value & mask)) begin
			report_mismatch($sformatf("register %0d reads %h, wrote %h", idx, prdata, value));
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (idx == dslp_pkg::REG_LABEL_LIMIT) cfg_label_limit = value[6:0];
		else cfg_domain_limit = value[8:0];
	endtask

	task automatic wait_drained();
		while (option_bytes_q.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// sender: holds a stalled beat, otherwise offers the next byte or idles
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_fire) void'(option_bytes_q.pop_front());
			if (!in_valid || in_fire) begin
				if (option_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data  <= option_bytes_q[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= out_hold || ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		dslp_pkg::out_beat_t want;
		if (!arst_n) begin
			in_fire <= 1'b0;
		end else begin
			in_fire <= in_valid && !in_stall;
			if (in_valid && !in_stall) decode_byte(in_data);
			if (out_valid && !out_stall) begin
				if (decoded_q.size() == 0) begin
					report_mismatch($sformatf("unexpected beat char %h kind %0d last %b",
						out_data.out_char, out_data.kind, out_data.last));
				end else begin
					want = decoded_q.pop_front();
					if (out_data.out_char !== want.out_char) begin
						report_mismatch($sformatf("out_char %h, expected %h",
							out_data.out_char, want.out_char));
					end
					if (out_data.kind !== want.kind) begin
						report_mismatch($sformatf("kind %0d, expected %0d", out_data.kind, want.kind));
					end
					if (out_data.last !== want.last) begin
						report_mismatch($sformatf("last %b, expected %b", out_data.last, want.last));
					end
					beats_checked++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int directed[$];
		directed = '{
			'h01, "A", 'h03, "z", dslp_pkg::CH_DASH, "9", 'h00,
			'h02, "a", dslp_pkg::CH_DASH, 'h00,
			'h41, 'h00,
			'h01, "q", 'h7F, 'h00,
			'h02, "x", 'h00,
			'h03, 'h161,
			'h00, 'h1FF
		};
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		out_stall     = 1'b0;
		out_hold      = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_fire       = 1'b0;
		send_idle_pct = 0;
		stall_pct     = 0;
		cycles        = 0;
		mismatches    = 0;
		items_queued  = 0;
		beats_checked = 0;
		domains_done  = 0;
		domains_dropped = 0;
		settings_run  = 1;
		cfg_label_limit  = dslp_pkg::LABEL_LIMIT_RST;
		cfg_domain_limit = dslp_pkg::DOMAIN_LIMIT_RST;
		pmode = PM_START;
		clear_domain();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i]) offer(directed[i][7:0], directed[i][8]);
		wait_drained();

		// long output hold-off while the sender keeps offering
		out_hold = 1'b1;
		fork
			begin
				repeat (300) @(posedge clk);
				out_hold = 1'b0;
			end
		join_none

		for (int p = 0; p < N_SETTINGS; p++) begin
			int goal;
			if (p != 0) begin
				set_register(dslp_pkg::REG_LABEL_LIMIT, label_set[p]);
				set_register(dslp_pkg::REG_DOMAIN_LIMIT, domain_set[p]);
				settings_run++;
			end
			for (int m = 0; m < 4; m++) begin
				case (m)
					0: begin send_idle_pct = 0;  stall_pct = 0;  end
					1: begin send_idle_pct = 73; stall_pct = 0;  end
					2: begin send_idle_pct = 0;  stall_pct = 73; end
					default: begin send_idle_pct = 17; stall_pct = 17; end
				endcase
				goal = items_queued + (cfg_label_limit == 0 ? 10 : 32);
				while (items_queued < goal) begin
					if ($urandom_range(9) < 8) queue_option();
					else queue_noise();
				end
				while (option_bytes_q.size() != 0) @(posedge clk);
			end
			// sender pauses until all predicted beats are out
			wait_drained();
		end

		$display("Ran %0d input bytes under %0d register settings and four idling mixes.",
			items_queued, settings_run);
		$display("Checked %0d result beats: %0d domains completed, %0d discarded.",
			beats_checked, domains_done, domains_dropped);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/dslp_pkg.sv
hw/rtl/dslp_front.sv
hw/rtl/dslp_queue.sv
hw/rtl/dslp_back.sv
hw/rtl/dns_search_list_label_parser_unit.sv
tb/tb_dns_search_list_label_parser_unit.sv
